FILE: rtl/cst_pkg.sv
`timescale 1ns / 1ps
package cst_pkg;

   localparam int MAX_RES = 5;

   localparam logic [1:0] EV_BYTE  = 2'd0;
   localparam logic [1:0] EV_TOKEN = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;
   localparam logic [1:0] EV_EOF   = 2'd3;

   localparam logic [5:0] KD_ID       = 6'd0;
   localparam logic [5:0] KD_NUM      = 6'd1;
   localparam logic [5:0] KD_CHR      = 6'd2;
   localparam logic [5:0] KD_STR      = 6'd3;
   localparam logic [5:0] KD_ELLIPSIS = 6'd32;
   localparam logic [5:0] KD_POINT    = 6'd33;
   localparam logic [5:0] KD_EOF      = 6'd43;
   localparam logic [5:0] KD_NONE     = 6'd63;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UNEXP    = 3'd1;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd2;
   localparam logic [2:0] ERR_OPEN_COM = 3'd3;
   localparam logic [2:0] ERR_POINT2   = 3'd4;
   localparam logic [2:0] ERR_OPEN_LIT = 3'd5;

   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   typedef enum logic [16:0] {
      MODE_IDLE     = 17'h00001,
      MODE_IDENT    = 17'h00002,
      MODE_ZERO     = 17'h00004,
      MODE_DEC      = 17'h00008,
      MODE_HEX      = 17'h00010,
      MODE_BIN      = 17'h00020,
      MODE_CH_OPEN  = 17'h00040,
      MODE_CH_ESC   = 17'h00080,
      MODE_CH_CLOSE = 17'h00100,
      MODE_STR      = 17'h00200,
      MODE_STR_ESC  = 17'h00400,
      MODE_OP       = 17'h00800,
      MODE_DOTS     = 17'h01000,
      MODE_LCOM     = 17'h02000,
      MODE_BCOM     = 17'h04000,
      MODE_BSTAR    = 17'h08000,
      MODE_HALT     = 17'h10000
   } cst_mode_type;

   typedef struct packed {
      logic [1:0] ev;
      logic [5:0] kind;
      logic [7:0] pay;
      logic [2:0] err;
   } cst_res_type;

   typedef struct packed {
      logic [2:0]            n;
      cst_res_type [MAX_RES-1:0] r;
   } cst_bundle_type;

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic is_hexd(input logic [7:0] b);
      return is_digit(b) || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
   endfunction

   function automatic logic is_ws(input logic [7:0] b);
      return b == " " || b == CH_NL || b == 8'h09 || b == 8'h0D;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      unique case (b)
         "a":     r = 8'd7;
         "b":     r = 8'd8;
         "e":     r = 8'h1B;
         "f":     r = 8'd12;
         "n":     r = 8'd10;
         "r":     r = 8'd13;
         "t":     r = 8'd9;
         "v":     r = 8'd11;
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic logic is_op_start(input logic [7:0] b);
      return b == "+" || b == "-" || b == "*" || b == "/" || b == "%" || b == "&" ||
             b == "|" || b == "^" || b == "=" || b == "!" || b == ">" || b == "<" ||
             b == ".";
   endfunction

   function automatic logic [5:0] punct_kind(input logic [7:0] b);
      logic [5:0] k;
      unique case (b)
         ",":     k = 6'd34;
         ":":     k = 6'd35;
         ";":     k = 6'd36;
         "(":     k = 6'd37;
         ")":     k = 6'd38;
         "{":     k = 6'd39;
         "}":     k = 6'd40;
         "[":     k = 6'd41;
         "]":     k = 6'd42;
         default: k = KD_NONE;
      endcase
      return k;
   endfunction

   // {single, doubled, followed by '='}
   function automatic logic [17:0] op_kinds(input logic [7:0] c);
      logic [17:0] k;
      unique case (c)
         "+":     k = {6'd6,  6'd4,    6'd5};
         "-":     k = {6'd9,  6'd7,    6'd8};
         "*":     k = {6'd11, KD_NONE, 6'd10};
         "/":     k = {6'd13, KD_NONE, 6'd12};
         "%":     k = {6'd15, KD_NONE, 6'd14};
         "&":     k = {6'd18, 6'd16,   6'd17};
         "|":     k = {6'd21, 6'd19,   6'd20};
         "^":     k = {6'd23, KD_NONE, 6'd22};
         "=":     k = {6'd25, 6'd24,   KD_NONE};
         "!":     k = {6'd27, KD_NONE, 6'd26};
         ">":     k = {6'd29, KD_NONE, 6'd28};
         "<":     k = {6'd31, KD_NONE, 6'd30};
         default: k = {KD_POINT, KD_NONE, KD_NONE};
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/cst_req_if.sv
`timescale 1ns / 1ps
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       has_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, has_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, has_byte, end_of_text, output ready);
endinterface

FILE: rtl/cst_rsp_if.sv
`timescale 1ns / 1ps
interface cst_rsp_if #(parameter int POSITION_BITS = 16);
   logic                     valid;
   logic                     ready;
   logic [1:0]               event_res;
   logic [5:0]               token_kind;
   logic [7:0]               payload;
   logic [2:0]               error_code;
   logic [POSITION_BITS-1:0] line;
   logic [POSITION_BITS-1:0] column;
   logic                     final_res;

   modport source (output valid, event_res, token_kind, payload, error_code, line, column,
                   final_res, input ready);
   modport sink   (input valid, event_res, token_kind, payload, error_code, line, column,
                   final_res, output ready);
endinterface

FILE: rtl/c_like_source_tokenizer.sv
`timescale 1ns / 1ps
// Streaming lexer for C-like source text.
// req: at most one source byte per transaction (text_byte, has_byte, end_of_text).
// rsp: token events; each request causes zero to five responses, the last
//      of which carries final_res. Payload bytes of identifiers, numbers and
//      literals come first, then the token-complete event.
// Front stage classifies the byte and updates lexer state in the cycle it
// is taken, and writes all of its events as one entry into a two-entry queue.
// The back stage plays the queue head out one event per cycle while rsp is ready.
// Responses are registered: each is played from the queue entry written when the request is taken.
// Throughput: one byte per cycle while rsp is ready and bytes yield at most one
// event; a byte with more events holds the back stage until all are played.
// Reset (synchronous) returns to line 1, column 1, empties the queue.
// When rsp stalls the queue fills and req.ready drops after two pending
// entries; no transaction is lost. After end_of_text the lexer starts
// fresh for the next text. Position counters saturate at 2**POSITION_BITS-1.
module c_like_source_tokenizer #(
   parameter int POSITION_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req,
   cst_rsp_if.source rsp
);
   import cst_pkg::*;

   logic                     push, room;
   cst_bundle_type           bundle;
   logic [POSITION_BITS-1:0] line_w [MAX_RES];
   logic [POSITION_BITS-1:0] col_w  [MAX_RES];

   cst_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .room   (room),
      .push   (push),
      .bundle (bundle),
      .line_o (line_w),
      .col_o  (col_w)
   );

   cst_back #(.POSITION_BITS(POSITION_BITS)) u_back (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .bundle (bundle),
      .line_i (line_w),
      .col_i  (col_w),
      .room   (room),
      .rsp    (rsp)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid right after reset");
   a_push_room: assert property (@(posedge clock) disable iff (reset) push |-> room)
      else $error("queue overflow");
   a_eof_final: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.event_res == EV_EOF |-> rsp.final_res)
      else $error("end-of-file event not last");
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.event_res == EV_ERROR) == (rsp.error_code != ERR_NONE)))
      else $error("error code mismatch");
endmodule

FILE: rtl/cst_front.sv
`timescale 1ns / 1ps
module cst_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   cst_req_if.sink                     req,
   input  logic                        room,
   output logic                        push,
   output cst_pkg::cst_bundle_type     bundle,
   output logic [POSITION_BITS-1:0]    line_o [cst_pkg::MAX_RES],
   output logic [POSITION_BITS-1:0]    col_o  [cst_pkg::MAX_RES]
);
   import cst_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   cst_mode_type             mode_ff, mode_in;
   logic [7:0]               held_ff, held_in;
   logic                     ps_ff, ps_in;
   logic [POSITION_BITS-1:0] row_ff, row_in, col_ff, col_in, tsc_ff, tsc_in;
   logic [7:0]               lit_ff, lit_in;

   logic                     accept;
   logic [2:0]               n;
   cst_res_type              r [MAX_RES];
   logic [POSITION_BITS-1:0] ln [MAX_RES];
   logic [POSITION_BITS-1:0] cl [MAX_RES];
   logic                     refeed, do_start, dec_path, in_lit;
   logic [7:0]               b;
   logic [17:0]              ok;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == POS_MAX) ? v : v + POS_ONE;
   endfunction

   assign req.ready = room;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (n != 3'd0);

   always_comb begin
      bundle.n = n;
      for (int i = 0; i < MAX_RES; i++) begin
         bundle.r[i] = r[i];
         line_o[i]   = ln[i];
         col_o[i]    = cl[i];
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      held_in  = held_ff;
      ps_in    = ps_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      tsc_in   = tsc_ff;
      lit_in   = lit_ff;
      n        = 3'd0;
      refeed   = 1'b0;
      do_start = 1'b0;
      dec_path = 1'b0;
      in_lit   = 1'b0;
      b        = req.text_byte;
      ok       = op_kinds(held_ff);
      for (int i = 0; i < MAX_RES; i++) begin
         r[i]  = '0;
         ln[i] = '0;
         cl[i] = '0;
      end

      if (req.has_byte) begin
         unique case (mode_ff)
            MODE_IDLE: do_start = 1'b1;
            MODE_IDENT: begin
               if (is_letter(b) || is_digit(b) || b == "_") begin
                  r[n] = '{EV_BYTE, KD_ID, b, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
               end else begin
                  r[n] = '{EV_TOKEN, KD_ID, 8'd0, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  mode_in = MODE_IDLE;
                  refeed  = 1'b1;
               end
            end
            MODE_ZERO: begin
               if (b == "x" || b == "b") begin
                  r[n] = '{EV_BYTE, KD_NUM, b, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  mode_in = (b == "x") ? MODE_HEX : MODE_BIN;
               end else begin
                  mode_in  = MODE_DEC;
                  dec_path = 1'b1;
               end
            end
            MODE_DEC: dec_path = 1'b1;
            MODE_HEX, MODE_BIN: begin
               if (b == CH_QUOTE) begin
               end else if ((mode_ff == MODE_HEX) ? is_hexd(b) : (b == "0" || b == "1")) begin
                  r[n] = '{EV_BYTE, KD_NUM, b, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
               end else begin
                  r[n] = '{EV_TOKEN, KD_NUM, 8'd0, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  mode_in = MODE_IDLE;
                  refeed  = 1'b1;
               end
            end
            MODE_CH_OPEN: begin
               in_lit = 1'b1;
               if (b == CH_BSLASH) mode_in = MODE_CH_ESC;
               else begin
                  lit_in  = b;
                  mode_in = MODE_CH_CLOSE;
               end
            end
            MODE_CH_ESC: begin
               in_lit  = 1'b1;
               lit_in  = unescape(b);
               mode_in = MODE_CH_CLOSE;
            end
            MODE_CH_CLOSE: begin
               in_lit = 1'b1;
               if (b == CH_QUOTE) begin
                  r[n] = '{EV_BYTE, KD_CHR, lit_ff, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  r[n] = '{EV_TOKEN, KD_CHR, 8'd0, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  r[n] = '{EV_ERROR, KD_ID, 8'd0, ERR_BAD_CHAR}; ln[n] = row_ff; cl[n] = col_ff;
                  n = n + 3'd1;
                  mode_in = MODE_HALT;
               end
            end
            MODE_STR: begin
               in_lit = 1'b1;
               if (b == CH_DQUOTE) begin
                  r[n] = '{EV_TOKEN, KD_STR, 8'd0, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  mode_in = MODE_IDLE;
               end else if (b == CH_BSLASH) mode_in = MODE_STR_ESC;
               else begin
                  r[n] = '{EV_BYTE, KD_STR, b, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
               end
            end
            MODE_STR_ESC: begin
               in_lit = 1'b1;
               r[n] = '{EV_BYTE, KD_STR, unescape(b), ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
               n = n + 3'd1;
               mode_in = MODE_STR;
            end
            MODE_OP: begin
               if (held_ff == "/" && b == "/") mode_in = MODE_LCOM;
               else if (held_ff == "/" && b == "*") mode_in = MODE_BCOM;
               else if (held_ff == ".") begin
                  if (b == ".") mode_in = MODE_DOTS;
                  else begin
                     r[n] = '{EV_TOKEN, KD_POINT, 8'd0, ERR_NONE}; ln[n] = row_ff;
                     cl[n] = tsc_ff;
                     n = n + 3'd1;
                     mode_in = MODE_IDLE;
                     refeed  = 1'b1;
                  end
               end else begin
                  mode_in = MODE_IDLE;
                  ln[n] = row_ff;
                  cl[n] = tsc_ff;
                  if (ok[11:6] != KD_NONE && b == held_ff)
                     r[n] = '{EV_TOKEN, ok[11:6], 8'd0, ERR_NONE};
                  else if (ok[5:0] != KD_NONE && b == "=")
                     r[n] = '{EV_TOKEN, ok[5:0], 8'd0, ERR_NONE};
                  else begin
                     r[n] = '{EV_TOKEN, ok[17:12], 8'd0, ERR_NONE};
                     refeed = 1'b1;
                  end
                  n = n + 3'd1;
               end
            end
            MODE_DOTS: begin
               mode_in = MODE_IDLE;
               if (b == ".") begin
                  r[n] = '{EV_TOKEN, KD_ELLIPSIS, 8'd0, ERR_NONE}; ln[n] = row_ff;
                  cl[n] = tsc_ff;
                  n = n + 3'd1;
               end else begin
                  r[n] = '{EV_TOKEN, KD_POINT, 8'd0, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
                  r[n] = '{EV_TOKEN, KD_POINT, 8'd0, ERR_NONE}; ln[n] = row_ff;
                  cl[n] = sat_inc(tsc_ff);
                  n = n + 3'd1;
                  refeed = 1'b1;
               end
            end
            MODE_LCOM: if (b == CH_NL) begin
               mode_in = MODE_IDLE;
               refeed  = 1'b1;
            end
            MODE_BCOM: if (b == "*") mode_in = MODE_BSTAR;
            MODE_BSTAR: begin
               if (b == "/") mode_in = MODE_IDLE;
               else if (b != "*") mode_in = MODE_BCOM;
            end
            MODE_HALT: ;
            default: ;
         endcase

         // a leading zero that does not open hex or binary continues as decimal
         if (dec_path) begin
            if (b == CH_QUOTE) begin
            end else if (is_digit(b)) begin
               r[n] = '{EV_BYTE, KD_NUM, b, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
               n = n + 3'd1;
            end else if (b == ".") begin
               if (ps_ff) begin
                  r[n] = '{EV_ERROR, KD_ID, 8'd0, ERR_POINT2}; ln[n] = row_ff; cl[n] = col_ff;
                  n = n + 3'd1;
                  mode_in = MODE_HALT;
               end else begin
                  ps_in = 1'b1;
                  r[n] = '{EV_BYTE, KD_NUM, b, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
                  n = n + 3'd1;
               end
            end else begin
               r[n] = '{EV_TOKEN, KD_NUM, 8'd0, ERR_NONE}; ln[n] = row_ff; cl[n] = tsc_ff;
               n = n + 3'd1;
               mode_in = MODE_IDLE;
               refeed  = 1'b1;
            end
         end

         if (do_start || refeed) begin
            tsc_in = col_ff;
            ln[n]  = row_ff;
            cl[n]  = col_ff;
            if (is_ws(b)) begin
            end else if (is_digit(b)) begin
               ps_in   = 1'b0;
               mode_in = (b == "0") ? MODE_ZERO : MODE_DEC;
               r[n] = '{EV_BYTE, KD_NUM, b, ERR_NONE};
               n = n + 3'd1;
            end else if (is_letter(b) || b == "_") begin
               mode_in = MODE_IDENT;
               r[n] = '{EV_BYTE, KD_ID, b, ERR_NONE};
               n = n + 3'd1;
            end else if (b == CH_QUOTE) mode_in = MODE_CH_OPEN;
            else if (b == CH_DQUOTE) mode_in = MODE_STR;
            else if (is_op_start(b)) begin
               held_in = b;
               mode_in = MODE_OP;
            end else if (punct_kind(b) != KD_NONE) begin
               r[n] = '{EV_TOKEN, punct_kind(b), 8'd0, ERR_NONE};
               n = n + 3'd1;
            end else begin
               r[n] = '{EV_ERROR, KD_ID, 8'd0, ERR_UNEXP};
               n = n + 3'd1;
               mode_in = MODE_HALT;
            end
         end

         if (b == CH_NL && !in_lit) begin
            row_in = sat_inc(row_ff);
            col_in = POS_ONE;
         end else begin
            col_in = sat_inc(col_ff);
         end
      end

      if (req.end_of_text) begin
         ok    = op_kinds(held_in);
         ln[n] = row_in;
         cl[n] = tsc_in;
         unique case (mode_in)
            MODE_IDENT: begin
               r[n] = '{EV_TOKEN, KD_ID, 8'd0, ERR_NONE};
               n = n + 3'd1;
            end
            MODE_ZERO, MODE_DEC, MODE_HEX, MODE_BIN: begin
               r[n] = '{EV_TOKEN, KD_NUM, 8'd0, ERR_NONE};
               n = n + 3'd1;
            end
            MODE_CH_OPEN, MODE_CH_ESC, MODE_CH_CLOSE, MODE_STR, MODE_STR_ESC: begin
               r[n] = '{EV_ERROR, KD_ID, 8'd0, ERR_OPEN_LIT};
               cl[n] = col_in;
               n = n + 3'd1;
            end
            MODE_OP: begin
               r[n] = '{EV_TOKEN, ok[17:12], 8'd0, ERR_NONE};
               n = n + 3'd1;
            end
            MODE_DOTS: begin
               r[n] = '{EV_TOKEN, KD_POINT, 8'd0, ERR_NONE};
               n = n + 3'd1;
               r[n] = '{EV_TOKEN, KD_POINT, 8'd0, ERR_NONE};
               ln[n] = row_in;
               cl[n] = sat_inc(tsc_in);
               n = n + 3'd1;
            end
            MODE_BCOM, MODE_BSTAR: begin
               r[n] = '{EV_ERROR, KD_ID, 8'd0, ERR_OPEN_COM};
               cl[n] = col_in;
               n = n + 3'd1;
            end
            default: ;
         endcase
         r[n]  = '{EV_EOF, KD_EOF, 8'd0, ERR_NONE};
         ln[n] = row_in;
         cl[n] = col_in;
         n = n + 3'd1;
         mode_in = MODE_IDLE;
         held_in = 8'd0;
         ps_in   = 1'b0;
         row_in  = POS_ONE;
         col_in  = POS_ONE;
         tsc_in  = '0;
         lit_in  = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         held_ff <= 8'd0;
         ps_ff   <= 1'b0;
         row_ff  <= POS_ONE;
         col_ff  <= POS_ONE;
         tsc_ff  <= '0;
         lit_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
         ps_ff   <= ps_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         tsc_ff  <= tsc_in;
         lit_ff  <= lit_in;
      end
   end
endmodule

FILE: rtl/cst_back.sv
`timescale 1ns / 1ps
module cst_back #(
   parameter int POSITION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cst_pkg::cst_bundle_type     bundle,
   input  logic [POSITION_BITS-1:0]    line_i [cst_pkg::MAX_RES],
   input  logic [POSITION_BITS-1:0]    col_i  [cst_pkg::MAX_RES],
   output logic                        room,
   cst_rsp_if.source                   rsp
);
   import cst_pkg::*;

   cst_bundle_type           q_ff [2];
   logic [POSITION_BITS-1:0] ln_ff [2][MAX_RES];
   logic [POSITION_BITS-1:0] cl_ff [2][MAX_RES];
   logic                     wr_ff, rd_ff;
   logic [1:0]               used_ff, used_in;
   logic [2:0]               idx_ff;
   logic                     last, pop;
   cst_res_type              cur;

   assign room  = used_ff != 2'd2;
   assign cur   = q_ff[rd_ff].r[idx_ff];
   assign last  = idx_ff == q_ff[rd_ff].n - 3'd1;
   assign pop   = rsp.valid && rsp.ready && last;

   assign rsp.valid      = used_ff != 2'd0;
   assign rsp.event_res  = cur.ev;
   assign rsp.token_kind = cur.kind;
   assign rsp.payload    = cur.pay;
   assign rsp.error_code = cur.err;
   assign rsp.line       = ln_ff[rd_ff][idx_ff];
   assign rsp.column     = cl_ff[rd_ff][idx_ff];
   assign rsp.final_res  = last;

   always_comb begin
      used_in = used_ff;
      if (push && !pop) used_in = used_ff + 2'd1;
      else if (!push && pop) used_in = used_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff]  <= bundle;
         ln_ff[wr_ff] <= line_i;
         cl_ff[wr_ff] <= col_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         used_ff <= 2'd0;
         idx_ff  <= 3'd0;
      end else begin
         used_ff <= used_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) begin
            rd_ff  <= ~rd_ff;
            idx_ff <= 3'd0;
         end else if (rsp.valid && rsp.ready) begin
            idx_ff <= idx_ff + 3'd1;
         end
      end
   end
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import cst_pkg::*;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       has_byte;
      logic       end_of_text;
   } text_item_type;

   typedef struct packed {
      logic [1:0]  ev;
      logic [5:0]  kind;
      logic [7:0]  pay;
      logic [2:0]  err;
      logic [15:0] line;
      logic [15:0] column;
      logic        last;
   } token_event_type;

   typedef enum logic [4:0] {
      LX_IDLE, LX_IDENT, LX_ZERO, LX_DEC, LX_HEX, LX_BIN, LX_CH_OPEN, LX_CH_ESC,
      LX_CH_CLOSE, LX_STR, LX_STR_ESC, LX_OP, LX_DOTS, LX_LCOM, LX_BCOM, LX_BSTAR,
      LX_HALT
   } lex_mode_type;

   localparam logic [15:0] POS_MAX = 16'hFFFF;
   localparam logic [7:0] NO_KIND = 8'd255;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cst_req_if req ();
   cst_rsp_if #(.POSITION_BITS(16)) rsp ();

   c_like_source_tokenizer #(.POSITION_BITS(16)) DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // lexer state of the predictor
   lex_mode_type lx_mode;
   logic [7:0]   lx_op;
   logic         lx_point;
   logic [15:0]  lx_row;
   logic [15:0]  lx_col;
   logic [15:0]  lx_start;
   logic [7:0]   lx_lit;

   text_item_type   pending_text[$];
   token_event_type expected_events[$];
   int error_count = 0;
   int send_idle_pct = 18;
   int recv_idle_pct = 52;
   logic hold_go = 1'b0;
   logic hold_active = 1'b0;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v < POS_MAX) ? v + 16'd1 : v;
   endfunction

   function automatic logic is_dig(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   endfunction

   function automatic logic [7:0] decode_escape(input logic [7:0] b);
      case (b)
         "a": return 8'd7;
         "b": return 8'd8;
         "e": return 8'h1B;
         "f": return 8'd12;
         "n": return 8'd10;
         "r": return 8'd13;
         "t": return 8'd9;
         "v": return 8'd11;
         default: return b;
      endcase
   endfunction

   // single, doubled and '='-suffixed kinds of an operator byte
   function automatic void operator_kinds(input logic [7:0] c, output logic [7:0] one,
                                          output logic [7:0] twin, output logic [7:0] asg);
      twin = NO_KIND;
      asg = NO_KIND;
      case (c)
         "+": begin one = 8'd6; twin = 8'd4; asg = 8'd5; end
         "-": begin one = 8'd9; twin = 8'd7; asg = 8'd8; end
         "*": begin one = 8'd11; asg = 8'd10; end
         "/": begin one = 8'd13; asg = 8'd12; end
         "%": begin one = 8'd15; asg = 8'd14; end
         "&": begin one = 8'd18; twin = 8'd16; asg = 8'd17; end
         "|": begin one = 8'd21; twin = 8'd19; asg = 8'd20; end
         "^": begin one = 8'd23; asg = 8'd22; end
         "=": begin one = 8'd25; twin = 8'd24; end
         "!": begin one = 8'd27; asg = 8'd26; end
         ">": begin one = 8'd29; asg = 8'd28; end
         "<": begin one = 8'd31; asg = 8'd30; end
         default: one = {2'b00, KD_POINT};
      endcase
   endfunction

   function automatic void add_event(input logic [1:0] ev, input logic [5:0] kind,
                                     input logic [7:0] pay, input logic [2:0] err,
                                     input logic [15:0] ln, input logic [15:0] cl,
                                     inout int n);
      token_event_type e;
      e = '{ev: ev, kind: kind, pay: pay, err: err, line: ln, column: cl, last: 1'b0};
      expected_events.insert(expected_events.size(), e);
      n++;
   endfunction

   function automatic void add_byte(input logic [5:0] kind, input logic [7:0] b, inout int n);
      add_event(EV_BYTE, kind, b, ERR_NONE, lx_row, lx_start, n);
   endfunction

   function automatic void add_token(input logic [5:0] kind, inout int n);
      add_event(EV_TOKEN, kind, 8'd0, ERR_NONE, lx_row, lx_start, n);
   endfunction

   function automatic void add_error(input logic [2:0] code, inout int n);
      add_event(EV_ERROR, 6'd0, 8'd0, code, lx_row, lx_col, n);
      lx_mode = LX_HALT;
   endfunction

   task automatic lexer_reset();
      lx_mode = LX_IDLE;
      lx_op = 8'd0;
      lx_point = 1'b0;
      lx_row = 16'd1;
      lx_col = 16'd1;
      lx_start = 16'd0;
      lx_lit = 8'd0;
   endtask

   function automatic void begin_token(input logic [7:0] b, inout int n);
      lx_start = lx_col;
      if (b == " " || b == CH_NL || b == 8'h09 || b == 8'h0D) return;
      if (is_dig(b)) begin
         lx_point = 1'b0;
         lx_mode = (b == "0") ? LX_ZERO : LX_DEC;
         add_byte(KD_NUM, b, n);
      end else if (is_alpha(b) || b == "_") begin
         lx_mode = LX_IDENT;
         add_byte(KD_ID, b, n);
      end else if (b == CH_QUOTE) begin
         lx_mode = LX_CH_OPEN;
      end else if (b == CH_DQUOTE) begin
         lx_mode = LX_STR;
      end else begin
         case (b)
            "+", "-", "*", "/", "%", "&", "|", "^", "=", "!", ">", "<", ".": begin
               lx_op = b;
               lx_mode = LX_OP;
            end
            ",": add_token(6'd34, n);
            ":": add_token(6'd35, n);
            ";": add_token(6'd36, n);
            "(": add_token(6'd37, n);
            ")": add_token(6'd38, n);
            "{": add_token(6'd39, n);
            "}": add_token(6'd40, n);
            "[": add_token(6'd41, n);
            "]": add_token(6'd42, n);
            default: add_error(ERR_UNEXP, n);
         endcase
      end
   endfunction

   // returns 1 when the byte has to be lexed again from idle
   function automatic logic lex_byte(input logic [7:0] b, inout int n);
      logic [7:0] one, twin, asg;
      case (lx_mode)
         LX_IDLE: begin begin_token(b, n); return 1'b0; end
         LX_IDENT: begin
            if (is_alpha(b) || is_dig(b) || b == "_") begin
               add_byte(KD_ID, b, n);
               return 1'b0;
            end
            add_token(KD_ID, n);
            lx_mode = LX_IDLE;
            return 1'b1;
         end
         LX_ZERO: begin
            if (b == "x" || b == "b") begin
               add_byte(KD_NUM, b, n);
               lx_mode = (b == "x") ? LX_HEX : LX_BIN;
               return 1'b0;
            end
            lx_mode = LX_DEC;
            return lex_byte(b, n);
         end
         LX_DEC, LX_HEX, LX_BIN: begin
            if (b == CH_QUOTE) return 1'b0;
            if ((lx_mode == LX_DEC && is_dig(b)) ||
                (lx_mode == LX_HEX && (is_dig(b) || (b >= "A" && b <= "F") ||
                                       (b >= "a" && b <= "f"))) ||
                (lx_mode == LX_BIN && (b == "0" || b == "1"))) begin
               add_byte(KD_NUM, b, n);
               return 1'b0;
            end
            if (lx_mode == LX_DEC && b == ".") begin
               if (lx_point) add_error(ERR_POINT2, n);
               else begin
                  lx_point = 1'b1;
                  add_byte(KD_NUM, b, n);
               end
               return 1'b0;
            end
            add_token(KD_NUM, n);
            lx_mode = LX_IDLE;
            return 1'b1;
         end
         LX_CH_OPEN: begin
            if (b == CH_BSLASH) lx_mode = LX_CH_ESC;
            else begin
               lx_lit = b;
               lx_mode = LX_CH_CLOSE;
            end
            return 1'b0;
         end
         LX_CH_ESC: begin
            lx_lit = decode_escape(b);
            lx_mode = LX_CH_CLOSE;
            return 1'b0;
         end
         LX_CH_CLOSE: begin
            if (b == CH_QUOTE) begin
               add_byte(KD_CHR, lx_lit, n);
               add_token(KD_CHR, n);
               lx_mode = LX_IDLE;
            end else add_error(ERR_BAD_CHAR, n);
            return 1'b0;
         end
         LX_STR: begin
            if (b == CH_DQUOTE) begin
               add_token(KD_STR, n);
               lx_mode = LX_IDLE;
            end else if (b == CH_BSLASH) lx_mode = LX_STR_ESC;
            else add_byte(KD_STR, b, n);
            return 1'b0;
         end
         LX_STR_ESC: begin
            add_byte(KD_STR, decode_escape(b), n);
            lx_mode = LX_STR;
            return 1'b0;
         end
         LX_OP: begin
            if (lx_op == "/" && b == "/") begin lx_mode = LX_LCOM; return 1'b0; end
            if (lx_op == "/" && b == "*") begin lx_mode = LX_BCOM; return 1'b0; end
            if (lx_op == ".") begin
               if (b == ".") begin lx_mode = LX_DOTS; return 1'b0; end
               add_token(KD_POINT, n);
               lx_mode = LX_IDLE;
               return 1'b1;
            end
            operator_kinds(lx_op, one, twin, asg);
            lx_mode = LX_IDLE;
            if (twin != NO_KIND && b == lx_op) begin add_token(twin[5:0], n); return 1'b0; end
            if (asg != NO_KIND && b == "=") begin add_token(asg[5:0], n); return 1'b0; end
            add_token(one[5:0], n);
            return 1'b1;
         end
         LX_DOTS: begin
            lx_mode = LX_IDLE;
            if (b == ".") begin add_token(KD_ELLIPSIS, n); return 1'b0; end
            add_token(KD_POINT, n);
            add_event(EV_TOKEN, KD_POINT, 8'd0, ERR_NONE, lx_row, sat_inc(lx_start), n);
            return 1'b1;
         end
         LX_LCOM: begin
            if (b == CH_NL) begin lx_mode = LX_IDLE; return 1'b1; end
            return 1'b0;
         end
         LX_BCOM: begin
            if (b == "*") lx_mode = LX_BSTAR;
            return 1'b0;
         end
         LX_BSTAR: begin
            if (b == "/") lx_mode = LX_IDLE;
            else if (b != "*") lx_mode = LX_BCOM;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic predict_events(input text_item_type it);
      int n;
      lex_mode_type m;
      logic [7:0] one, twin, asg;
      n = 0;
      if (it.has_byte) begin
         m = lx_mode;
         for (int p = 0; p < 3; p++) begin
            m = lx_mode;
            if (!lex_byte(it.text_byte, n)) break;
         end
         if (it.text_byte == CH_NL && !(m >= LX_CH_OPEN && m <= LX_STR_ESC)) begin
            lx_row = sat_inc(lx_row);
            lx_col = 16'd1;
         end else lx_col = sat_inc(lx_col);
      end
      if (it.end_of_text) begin
         case (lx_mode)
            LX_IDENT: add_token(KD_ID, n);
            LX_ZERO, LX_DEC, LX_HEX, LX_BIN: add_token(KD_NUM, n);
            LX_CH_OPEN, LX_CH_ESC, LX_CH_CLOSE, LX_STR, LX_STR_ESC: add_error(ERR_OPEN_LIT, n);
            LX_OP: begin
               operator_kinds(lx_op, one, twin, asg);
               add_token((lx_op == ".") ? KD_POINT : one[5:0], n);
            end
            LX_DOTS: begin
               add_token(KD_POINT, n);
               add_event(EV_TOKEN, KD_POINT, 8'd0, ERR_NONE, lx_row, sat_inc(lx_start), n);
            end
            LX_BCOM, LX_BSTAR: add_error(ERR_OPEN_COM, n);
            default: ;
         endcase
         add_event(EV_EOF, KD_EOF, 8'd0, ERR_NONE, lx_row, lx_col, n);
         lexer_reset();
      end
      if (n > 0) expected_events[$].last = 1'b1;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.text_byte <= 8'd0;
         req.has_byte <= 1'b0;
         req.end_of_text <= 1'b0;
         lexer_reset();
      end else if (!req.valid || req.ready) begin
         if (req.valid) predict_events(text_item_type'{req.text_byte, req.has_byte,
                                                       req.end_of_text});
         if (pending_text.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            text_item_type it;
            it = pending_text.pop_front();
            req.valid <= 1'b1;
            req.text_byte <= it.text_byte;
            req.has_byte <= it.has_byte;
            req.end_of_text <= it.end_of_text;
         end else req.valid <= 1'b0;
      end
   end

   // long receiver stall, counted here
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (200) @(posedge clock);
      hold_active <= 1'b0;
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            token_event_type want;
            if (expected_events.size() == 0) begin
               error_count++;
               $display("%0t transaction with no expectation", $realtime);
            end else begin
               want = expected_events.pop_front();
               if (rsp.event_res !== want.ev)
                  report_mismatch("event", 32'(rsp.event_res), 32'(want.ev));
               if (rsp.token_kind !== want.kind)
                  report_mismatch("kind", 32'(rsp.token_kind), 32'(want.kind));
               if (rsp.payload !== want.pay)
                  report_mismatch("payload", 32'(rsp.payload), 32'(want.pay));
               if (rsp.error_code !== want.err)
                  report_mismatch("error", 32'(rsp.error_code), 32'(want.err));
               if (rsp.line !== want.line)
                  report_mismatch("line", 32'(rsp.line), 32'(want.line));
               if (rsp.column !== want.column)
                  report_mismatch("column", 32'(rsp.column), 32'(want.column));
               if (rsp.final_res !== want.last)
                  report_mismatch("final", 32'(rsp.final_res), 32'(want.last));
            end
         end
         if (hold_active) rsp.ready <= 1'b0;
         else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_text.insert(pending_text.size(), text_item_type'{b, 1'b1, 1'b0});
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_end();
      pending_text.insert(pending_text.size(), text_item_type'{8'd0, 1'b0, 1'b1});
   endtask

   task automatic drain();
      while (pending_text.size() > 0 || req.valid || expected_events.size() > 0)
         @(posedge clock);
   endtask

   function automatic string random_fragment();
      string frags[] = '{"abc_1 ", "0x1F'a ", "0b10'1;", "12.5 ", "'\\n'", "\"hi\\tq\"",
                         "a+=b++", "x&&y||z", "...", "..x", "/*c**/", "// c\n", "==!=",
                         ">=<=", "-- -=", "%=^=|", "(a)[b]{c}", ",:;", "0.5.", "\n",
                         "'q'", "\\", "\t\r", "*=/=", "f(0)"};
      return frags[$urandom_range(frags.size() - 1)];
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: operators, literals, escapes, numbers, comments, dots
      push_text("id_9 0x'Ff 0b1'0 09.5;'\\e''x'\"a\\q\\n\"+++=-->=!=..");
      push_text("... .5 a.b /* x */ */ // z\n&&&=|||=^=%*=/");
      push_end();
      push_text("1.2.3");
      push_end();
      push_text("'ab");
      push_end();
      push_byte(8'hFF);
      push_byte(8'h00);
      push_end();
      push_text("/* open");
      push_end();
      push_text("'x");
      pending_text.insert(pending_text.size(), text_item_type'{8'd0, 1'b0, 1'b0});
      push_end();
      push_text("\"str\n");
      push_end();
      push_text("..");
      push_end();
      drain();

      // receiver holds off long while sender keeps offering
      hold_go = 1'b1;
      push_text("a+b*c;");
      push_end();
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 52 : 0;
         recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 18 : 0;
         for (int k = 0; k < 105; ) begin
            if ($urandom_range(9) < 8) begin
               string s;
               s = random_fragment();
               push_text(s);
               k += s.len();
            end else begin
               text_item_type it;
               it.text_byte = 8'($urandom());
               it.has_byte = ($urandom_range(15) != 0);
               it.end_of_text = ($urandom_range(19) == 0);
               pending_text.insert(pending_text.size(), it);
               k++;
            end
            if ($urandom_range(7) == 0) begin
               push_end();
               k++;
            end
         end
         push_end();
         drain();
      end
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_events.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/cst_pkg.sv
rtl/cst_req_if.sv
rtl/cst_rsp_if.sv
rtl/cst_front.sv
rtl/cst_back.sv
rtl/c_like_source_tokenizer.sv
sim/tb_top.sv
